FILE: hdl/fmac_pkg.sv
// Shared types, command codes and AES/CMAC helper functions for the frame MIC block.
`timescale 1ns / 1ps

package fmac_pkg;

    typedef logic [2:0] cmd_kind_t;

    localparam cmd_kind_t CMD_HDR     = 3'd0;
    localparam cmd_kind_t CMD_HDR_FIN = 3'd1;
    localparam cmd_kind_t CMD_CHAIN   = 3'd2;
    localparam cmd_kind_t CMD_FIN1    = 3'd3;
    localparam cmd_kind_t CMD_FIN2    = 3'd4;

    localparam logic [7:0] HDR_TAG  = 8'h49;
    localparam logic [7:0] CMAC_RB  = 8'h87;
    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam int         BLK      = 16;

    typedef struct packed {
        cmd_kind_t    kind;
        logic [127:0] blk;
    } cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES key schedule step; byte 0 sits in bits 127:120.
    function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] tmp;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        tmp = {sbox(rk[23:16]) ^ rcon, sbox(rk[15:8]), sbox(rk[7:0]), sbox(rk[31:24])};
        w0  = rk[127:96] ^ tmp;
        w1  = rk[95:64] ^ w0;
        w2  = rk[63:32] ^ w1;
        w3  = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   all;
        logic [127:0] res;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4 * c] = sbox(s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int k = 0; k < 16; k++) begin
            res[127 - 8 * k -: 8] = (last ? t[k] : m[k]) ^ rk[127 - 8 * k -: 8];
        end
        return res;
    endfunction

    // Multiply by x in GF(2^128).
    function automatic logic [127:0] dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, CMAC_RB} : 128'd0);
    endfunction

endpackage

FILE: hdl/fmac_front.sv
// Input side: accepts transactions, gathers frame bytes into blocks and issues block commands.
`timescale 1ns / 1ps

module fmac_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [7:0]         s_data_byte,
    input  logic [7:0]         s_frame_length,
    input  logic [31:0]        s_dev_address,
    input  logic [31:0]        s_frame_count,
    input  logic               s_direction,
    output logic               push,
    output fmac_pkg::cmd_t     push_cmd,
    input  logic               q_full
);

    logic [127:0] buf_reg, buf_next;
    logic [7:0]   seen_reg, seen_next;
    logic [7:0]   len_reg, len_next;
    logic         in_frame_reg, in_frame_next;
    logic [127:0] filled;
    logic [3:0]   pos;
    logic         take;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign pos     = seen_reg[3:0];

    always_comb begin
        filled = buf_reg;
        filled[127 - 8 * pos -: 8] = s_data_byte;
    end

    always_comb begin
        buf_next      = buf_reg;
        seen_next     = seen_reg;
        len_next      = len_reg;
        in_frame_next = in_frame_reg;
        push          = 1'b0;
        push_cmd.kind = fmac_pkg::CMD_CHAIN;
        push_cmd.blk  = filled;
        if (take) begin
            if (!s_op) begin
                push         = 1'b1;
                push_cmd.blk = {fmac_pkg::HDR_TAG, 32'd0, 7'd0, s_direction,
                                s_dev_address[7:0], s_dev_address[15:8],
                                s_dev_address[23:16], s_dev_address[31:24],
                                s_frame_count[7:0], s_frame_count[15:8],
                                s_frame_count[23:16], s_frame_count[31:24],
                                8'd0, s_frame_length};
                push_cmd.kind = (s_frame_length == 8'd0) ? fmac_pkg::CMD_HDR_FIN
                                                         : fmac_pkg::CMD_HDR;
                buf_next      = '0;
                seen_next     = '0;
                len_next      = s_frame_length;
                in_frame_next = (s_frame_length != 8'd0);
            end else if (in_frame_reg) begin
                seen_next = seen_reg + 8'd1;
                buf_next  = filled;
                if (seen_next == len_reg) begin
                    in_frame_next = 1'b0;
                    push          = 1'b1;
                    if (pos == 4'd15) begin
                        push_cmd.kind = fmac_pkg::CMD_FIN1;
                    end else begin
                        push_cmd.kind = fmac_pkg::CMD_FIN2;
                        push_cmd.blk[127 - 8 * (pos + 4'd1) -: 8] = fmac_pkg::PAD_MARK;
                    end
                end else if (pos == 4'd15) begin
                    push     = 1'b1;
                    buf_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg     <= '0;
            len_reg      <= '0;
            in_frame_reg <= 1'b0;
        end else begin
            seen_reg     <= seen_next;
            len_reg      <= len_next;
            in_frame_reg <= in_frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

endmodule

FILE: hdl/fmac_queue.sv
// Two-entry command queue between the input side and the cipher side.
`timescale 1ns / 1ps

module fmac_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fmac_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output fmac_pkg::cmd_t q_cmd
);

    fmac_pkg::cmd_t ent_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = ent_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/fmac_aes.sv
// Iterative AES-128 encryptor: one round per cycle with on-the-fly key expansion.
`timescale 1ns / 1ps

module fmac_aes (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] blk_in,
    output logic         busy,
    output logic         done,
    output logic [127:0] result
);

    logic [127:0] st_reg, rk_reg, rk_n;
    logic [7:0]   rcon_reg;
    logic [3:0]   rnd_reg;
    logic         busy_reg, done_reg;

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = st_reg;
    assign rk_n   = fmac_pkg::key_next(rk_reg, rcon_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
            end else if (busy_reg) begin
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == 4'd10) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            st_reg   <= blk_in ^ key;
            rk_reg   <= key;
            rcon_reg <= 8'h01;
        end else if (busy_reg) begin
            st_reg   <= fmac_pkg::aes_round(st_reg, rk_n, rnd_reg == 4'd10);
            rk_reg   <= rk_n;
            rcon_reg <= fmac_pkg::xtime(rcon_reg);
        end
    end

endmodule

FILE: hdl/fmac_back.sv
// Cipher side: runs block commands through AES, keeps chain and subkeys, holds the result.
`timescale 1ns / 1ps

module fmac_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [127:0]   key,
    input  logic           q_valid,
    input  fmac_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_mic
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_BLK  = 2'd2;

    logic [1:0]     state_reg, state_next;
    fmac_pkg::cmd_t cmd_reg, cmd_next;
    logic [127:0]   chain_reg, chain_next;
    logic [127:0]   k1_reg, k1_next, k2_reg, k2_next;
    logic [31:0]    mic_reg, mic_next;
    logic           out_valid_reg, out_valid_next;
    logic           aes_start, aes_busy, aes_done;
    logic [127:0]   aes_blk, aes_res, l_dbl;

    function automatic logic is_final(input fmac_pkg::cmd_kind_t k);
        return (k == fmac_pkg::CMD_HDR_FIN) || (k == fmac_pkg::CMD_FIN1) ||
               (k == fmac_pkg::CMD_FIN2);
    endfunction

    fmac_aes u_aes (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (aes_start),
        .key    (key),
        .blk_in (aes_blk),
        .busy   (aes_busy),
        .done   (aes_done),
        .result (aes_res)
    );

    assign m_valid = out_valid_reg;
    assign m_mic   = mic_reg;
    assign l_dbl   = fmac_pkg::dbl(aes_res);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        chain_next     = chain_reg;
        k1_next        = k1_reg;
        k2_next        = k2_reg;
        mic_next       = mic_reg;
        out_valid_next = out_valid_reg;
        aes_start      = 1'b0;
        aes_blk        = '0;
        pop            = 1'b0;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && (!is_final(q_cmd.kind) || !out_valid_reg)) begin
                    pop       = 1'b1;
                    cmd_next  = q_cmd;
                    aes_start = 1'b1;
                    case (q_cmd.kind) inside
                        fmac_pkg::CMD_HDR, fmac_pkg::CMD_HDR_FIN: begin
                            aes_blk    = '0;
                            state_next = ST_KEY;
                        end
                        fmac_pkg::CMD_FIN1: begin
                            aes_blk    = q_cmd.blk ^ k1_reg ^ chain_reg;
                            state_next = ST_BLK;
                        end
                        fmac_pkg::CMD_FIN2: begin
                            aes_blk    = q_cmd.blk ^ k2_reg ^ chain_reg;
                            state_next = ST_BLK;
                        end
                        default: begin
                            aes_blk    = q_cmd.blk ^ chain_reg;
                            state_next = ST_BLK;
                        end
                    endcase
                end
            end
            ST_KEY: begin
                if (aes_done) begin
                    k1_next    = l_dbl;
                    k2_next    = fmac_pkg::dbl(l_dbl);
                    aes_start  = 1'b1;
                    aes_blk    = (cmd_reg.kind == fmac_pkg::CMD_HDR_FIN) ? (cmd_reg.blk ^ l_dbl)
                                                                         : cmd_reg.blk;
                    state_next = ST_BLK;
                end
            end
            ST_BLK: begin
                if (aes_done) begin
                    if (is_final(cmd_reg.kind)) begin
                        mic_next       = {aes_res[103:96], aes_res[111:104],
                                          aes_res[119:112], aes_res[127:120]};
                        out_valid_next = 1'b1;
                    end else begin
                        chain_next = aes_res;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        chain_reg <= chain_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        mic_reg   <= mic_next;
    end

    a_idle_no_aes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !aes_busy)
        else $error("cipher busy while command side idle");

    a_final_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && is_final(q_cmd.kind)) |-> !out_valid_reg)
        else $error("final command started with result slot occupied");

    a_result_from_block: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_BLK && aes_done))
        else $error("result raised outside block completion");

endmodule

FILE: hdl/frame_mic_aes_cmac.sv
// Top level of the frame MIC engine: AES-128-CMAC over header block and frame bytes.
`timescale 1ns / 1ps

//  channel  | ports                                         | moves
//  ---------+-----------------------------------------------+---------------------------
//  input    | s_valid/s_ready, s_op, s_data_byte, ...       | start or one frame byte
//  result   | m_valid/m_ready, m_mic                        | 32-bit tag, byte 0 low
//  config   | cfg_wr_en, cfg_index, cfg_wdata               | key half write
//
// An input transaction is accepted whenever the two-entry command queue has room.
// An AES block runs through the iterative round unit; a start costs two chained encryptions
// (subkey, then header), and each 16-byte block one more, so the byte stream runs at one
// transaction per cycle, stalling only when the queue fills.
// aresetn is synchronous, active low, and clears control state and the key registers only.
// A held result in the output register does not stop input; only a second final block waits.

module frame_mic_aes_cmac (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_frame_length,
    input  logic [31:0] s_dev_address,
    input  logic [31:0] s_frame_count,
    input  logic        s_direction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_mic
);

    localparam logic REG_KEY_UPPER = 1'b0;
    localparam logic REG_KEY_LOWER = 1'b1;

    logic [63:0]    key_upper_reg, key_lower_reg;
    logic           push, q_full, pop, q_valid;
    fmac_pkg::cmd_t push_cmd, q_cmd;

    // Key halves; byte 0 of the key sits in the top byte of the upper half.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KEY_UPPER: key_upper_reg <= cfg_wdata;
                REG_KEY_LOWER: key_lower_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: classify transactions, build header and data blocks.
    fmac_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_byte   (s_data_byte),
        .s_frame_length(s_frame_length),
        .s_dev_address (s_dev_address),
        .s_frame_count (s_frame_count),
        .s_direction   (s_direction),
        .push          (push),
        .push_cmd      (push_cmd),
        .q_full        (q_full)
    );

    // Queue: decouple byte intake from the cipher.
    fmac_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .q_cmd   (q_cmd)
    );

    // Back: subkeys, chaining and final tag.
    fmac_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .key    ({key_upper_reg, key_lower_reg}),
        .q_valid(q_valid),
        .q_cmd  (q_cmd),
        .pop    (pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_mic  (m_mic)
    );

endmodule
